// ===== rtl/core/segment_obstacle_collision_check_macros.svh =====
// Assertion macros used by the port checker of the collision check block.
`ifndef SEGMENT_OBSTACLE_COLLISION_CHECK_MACROS_SVH
`define SEGMENT_OBSTACLE_COLLISION_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define SOC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define SOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after any cycle with reset applied.
`define SOC_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/soc_pkg.sv =====
// Shared constants and types of the segment versus obstacle collision check.
`timescale 1ns / 1ps

package soc_pkg;

  // Table size and coordinate precision.
  localparam int MAX_OBSTACLES = 16;
  localparam int COORD_BITS    = 16;
  localparam int SPAN_BITS     = COORD_BITS - 1;
  localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
  localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  // Datapath widths: endpoint differences, multiplier operands, products and
  // differences of products.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int OPW    = COORD_BITS + 2;
  localparam int PROD_W = 2 * OPW;
  localparam int NUM_W  = PROD_W + 1;

  // Products formed for each obstacle, and the slot each one lands in.
  localparam int NUM_PRODUCTS = 6;
  localparam int SLOT_W       = 3;
  localparam logic [SLOT_W-1:0] SLOT_DY_XL = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_DX_YT = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_DX_YB = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_SX_DY = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_DY_XR = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_SY_DX = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 4'd1;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // One stored rectangle.
  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] bottom;
    logic [SPAN_BITS-1:0]  span_x;
    logic [SPAN_BITS-1:0]  span_y;
  } obstacle_t;

  // Request to and response from the shared multiplier.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [OPW-1:0]    a;
    logic [OPW-1:0]    b;
  } mul_req_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

// ===== rtl/core/soc_ifs.sv =====
// Channel interfaces of the collision check: input, result and configuration.
`timescale 1ns / 1ps

interface soc_in_if import soc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] obstacle_left;
  logic signed [COORD_BITS-1:0] obstacle_bottom;
  logic        [SPAN_BITS-1:0]  obstacle_span_x;
  logic        [SPAN_BITS-1:0]  obstacle_span_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, operation, obstacle_left, obstacle_bottom, obstacle_span_x,
           obstacle_span_y, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, operation, obstacle_left, obstacle_bottom, obstacle_span_x,
           obstacle_span_y, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface soc_out_if ();
  logic valid;
  logic ready;
  logic path_clear;
  logic table_full;

  modport source (output valid, path_clear, table_full, input ready);
  modport sink (input valid, path_clear, table_full, output ready);
endinterface

interface soc_cfg_if import soc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPAN_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/soc_mul_unit.sv =====
// Shared signed multiplier with a registered product and slot tag.
`timescale 1ns / 1ps

module soc_mul_unit import soc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                     rsp_valid_r;
  logic [SLOT_W-1:0]        slot_r;
  logic signed [PROD_W-1:0] product_r;

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else begin
      rsp_valid_r <= req.valid;
    end
  end

  // Full precision product of the two operands.
  always_ff @(posedge clk) begin
    if (req.valid) begin
      slot_r    <= req.slot;
      product_r <= PROD_W'($signed(req.a)) * PROD_W'($signed(req.b));
    end
  end

  assign rsp.valid   = rsp_valid_r;
  assign rsp.slot    = slot_r;
  assign rsp.product = product_r;

endmodule

// ===== rtl/core/segment_obstacle_collision_check.sv =====
// Steps: a load, or a check settled by the map bounds or an empty table, passes from acceptance
// through the finish state to the registered result; any other check walks the N stored
// obstacles, forming six products per obstacle through one shared multiplier followed
// by evaluations of the top, bottom, left and right edges, and a hit ends the walk early.
// Occupancy: one transaction in work at a time, and a result still stalled at the output holds
// back the next one. Reset clears the obstacle count and sets both map bounds to 50; the table
// contents are not cleared and only entries below the count are ever read.
`timescale 1ns / 1ps

module segment_obstacle_collision_check import soc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  soc_in_if.sink   in_if,
  soc_out_if.source out_if,
  soc_cfg_if.sink  cfg_if
);

  localparam logic [SPAN_BITS-1:0] MAP_RESET = SPAN_BITS'(50);
  localparam int NUM_EDGES = 4;
  localparam logic [SLOT_W-1:0] EDGE_TOP    = 3'd0;
  localparam logic [SLOT_W-1:0] EDGE_BOTTOM = 3'd1;
  localparam logic [SLOT_W-1:0] EDGE_LEFT   = 3'd2;
  localparam logic [SLOT_W-1:0] EDGE_RIGHT  = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIFF,
    ST_MUL,
    ST_WAIT,
    ST_EDGE,
    ST_FINISH
  } state_t;

  // True when n / d lies in [0, 1], ends included, for d not zero.
  function automatic logic ratio_wide(input logic signed [NUM_W-1:0] n,
                                      input logic signed [NUM_W-1:0] d);
    logic ok;
    if (d > 0) begin
      ok = (n >= 0) && (n <= d);
    end else begin
      ok = (n <= 0) && (n >= d);
    end
    return ok;
  endfunction

  function automatic logic ratio_narrow(input logic signed [OPW-1:0] n,
                                        input logic signed [OPW-1:0] d);
    logic ok;
    if (d > 0) begin
      ok = (n >= 0) && (n <= d);
    end else begin
      ok = (n <= 0) && (n >= d);
    end
    return ok;
  endfunction

  state_t state_r;

  logic [SPAN_BITS-1:0] map_width_r;
  logic [SPAN_BITS-1:0] map_height_r;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SLOT_W-1:0]    step_r;

  obstacle_t mem [MAX_OBSTACLES];
  obstacle_t rd_data_r;

  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [DIFF_W-1:0]     dx_r, dy_r;
  logic signed [COORD_BITS-1:0] l_r, b_r;
  logic signed [OPW-1:0]        rt_r, t_r;
  logic        [SPAN_BITS-1:0]  sx_r, sy_r;
  logic signed [OPW-1:0]        xl_r, xr_r, yt_r, yb_r;
  logic signed [PROD_W-1:0]     prod_r [NUM_PRODUCTS];

  logic res_clear_r;
  logic res_full_r;
  logic out_valid_r;
  logic out_path_clear_r;
  logic out_table_full_r;

  logic      in_ready;
  logic      in_accept;
  logic      table_is_full;
  logic      load_write;
  logic      a_inside;
  logic      b_inside;
  logic      point_hit;
  logic      last_obstacle;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;

  logic signed [OPW-1:0]    near_n, near_d;
  logic signed [PROD_W-1:0] far_a, far_b, den_p;
  logic signed [NUM_W-1:0]  far_n, far_d;
  logic                     edge_hit;

  // Handshake and decode of the input transaction.
  assign in_ready      = (state_r == ST_IDLE);
  assign in_if.ready   = in_ready;
  assign in_accept     = in_if.valid && in_ready;
  assign table_is_full = (count_r == CNT_W'(MAX_OBSTACLES));
  assign load_write    = in_accept && (in_if.operation == OP_LOAD) && !table_is_full;

  // Both endpoints must lie strictly inside the map.
  assign a_inside = (in_if.start_x > 0) && (in_if.start_y > 0) &&
                    (in_if.start_x < $signed({1'b0, map_width_r})) &&
                    (in_if.start_y < $signed({1'b0, map_height_r}));
  assign b_inside = (in_if.end_x > 0) && (in_if.end_y > 0) &&
                    (in_if.end_x < $signed({1'b0, map_width_r})) &&
                    (in_if.end_y < $signed({1'b0, map_height_r}));

  // Either endpoint inside the current rectangle, edges included.
  assign point_hit = ((ax_r >= l_r) && (ax_r <= rt_r) && (ay_r >= b_r) && (ay_r <= t_r)) ||
                     ((bx_r >= l_r) && (bx_r <= rt_r) && (by_r >= b_r) && (by_r <= t_r));

  assign last_obstacle = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // Operand selection for the shared multiplier, one product per cycle.
  always_comb begin
    mul_req.valid = (state_r == ST_MUL);
    mul_req.slot  = step_r;
    case (step_r)
      SLOT_DY_XL: begin
        mul_req.a = OPW'(dy_r);
        mul_req.b = xl_r;
      end
      SLOT_DX_YT: begin
        mul_req.a = OPW'(dx_r);
        mul_req.b = yt_r;
      end
      SLOT_DX_YB: begin
        mul_req.a = OPW'(dx_r);
        mul_req.b = yb_r;
      end
      SLOT_SX_DY: begin
        mul_req.a = OPW'(sx_r);
        mul_req.b = OPW'(dy_r);
      end
      SLOT_DY_XR: begin
        mul_req.a = OPW'(dy_r);
        mul_req.b = xr_r;
      end
      SLOT_SY_DX: begin
        mul_req.a = OPW'(sy_r);
        mul_req.b = OPW'(dx_r);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  soc_mul_unit u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Products land in their slots in the cycle after the multiplier registers them.
  always_ff @(posedge clk) begin
    if (mul_rsp.valid) begin
      prod_r[mul_rsp.slot] <= $signed(mul_rsp.product);
    end
  end

  // Edge test. The positive span cancels from the first ratio, so it needs only the
  // endpoint offset against the negated segment extent; the second ratio uses products.
  always_comb begin
    near_n = '0;
    near_d = '0;
    far_a  = '0;
    far_b  = '0;
    den_p  = '0;
    case (step_r)
      EDGE_TOP: begin
        near_n = yt_r;
        near_d = -OPW'(dy_r);
        far_a  = prod_r[SLOT_DX_YT];
        far_b  = prod_r[SLOT_DY_XL];
        den_p  = prod_r[SLOT_SX_DY];
      end
      EDGE_BOTTOM: begin
        near_n = yb_r;
        near_d = -OPW'(dy_r);
        far_a  = prod_r[SLOT_DX_YB];
        far_b  = prod_r[SLOT_DY_XL];
        den_p  = prod_r[SLOT_SX_DY];
      end
      EDGE_LEFT: begin
        near_n = xl_r;
        near_d = -OPW'(dx_r);
        far_a  = prod_r[SLOT_DX_YT];
        far_b  = prod_r[SLOT_DY_XL];
        den_p  = prod_r[SLOT_SY_DX];
      end
      EDGE_RIGHT: begin
        near_n = xr_r;
        near_d = -OPW'(dx_r);
        far_a  = prod_r[SLOT_DX_YT];
        far_b  = prod_r[SLOT_DY_XR];
        den_p  = prod_r[SLOT_SY_DX];
      end
      default: begin
        near_n = '0;
      end
    endcase
    far_n    = NUM_W'(far_a) - NUM_W'(far_b);
    far_d    = -NUM_W'(den_p);
    edge_hit = (den_p != 0) && ratio_narrow(near_n, near_d) && ratio_wide(far_n, far_d);
  end

  // Obstacle table: written on a load, read at the walk index with registered data.
  always_ff @(posedge clk) begin
    if (load_write) begin
      mem[count_r[IDX_W-1:0]] <= '{left:   in_if.obstacle_left,
                                    bottom: in_if.obstacle_bottom,
                                    span_x: in_if.obstacle_span_x,
                                    span_y: in_if.obstacle_span_y};
    end
    rd_data_r <= mem[idx_r];
  end

  // Configuration registers; writes are always taken.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_RESET;
      map_height_r <= MAP_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MAP_WIDTH:  map_width_r  <= cfg_if.data;
        REG_MAP_HEIGHT: map_height_r <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: walks the stored obstacles and holds the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result is dropped here unless the finish step replaces it this cycle.
      if (out_valid_r && out_if.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_if.operation == OP_LOAD) begin
              res_clear_r <= 1'b0;
              res_full_r  <= table_is_full;
              if (!table_is_full) begin
                count_r <= count_r + CNT_W'(1);
              end
              state_r <= ST_FINISH;
            end else begin
              ax_r        <= in_if.start_x;
              ay_r        <= in_if.start_y;
              bx_r        <= in_if.end_x;
              by_r        <= in_if.end_y;
              dx_r        <= DIFF_W'(in_if.end_x) - DIFF_W'(in_if.start_x);
              dy_r        <= DIFF_W'(in_if.end_y) - DIFF_W'(in_if.start_y);
              res_clear_r <= a_inside && b_inside;
              res_full_r  <= 1'b0;
              idx_r       <= '0;
              if (!(a_inside && b_inside) || (count_r == '0)) begin
                state_r <= ST_FINISH;
              end else begin
                state_r <= ST_READ;
              end
            end
          end
        end
        ST_READ: begin
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          l_r     <= $signed(rd_data_r.left);
          b_r     <= $signed(rd_data_r.bottom);
          sx_r    <= rd_data_r.span_x;
          sy_r    <= rd_data_r.span_y;
          rt_r    <= OPW'($signed(rd_data_r.left)) + $signed(OPW'(rd_data_r.span_x));
          t_r     <= OPW'($signed(rd_data_r.bottom)) + $signed(OPW'(rd_data_r.span_y));
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          xl_r   <= OPW'(ax_r) - OPW'(l_r);
          xr_r   <= OPW'(ax_r) - rt_r;
          yt_r   <= OPW'(ay_r) - t_r;
          yb_r   <= OPW'(ay_r) - OPW'(b_r);
          step_r <= '0;
          if (point_hit) begin
            res_clear_r <= 1'b0;
            state_r     <= ST_FINISH;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_r <= step_r + SLOT_W'(1);
          if (step_r == SLOT_W'(NUM_PRODUCTS - 1)) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          step_r  <= '0;
          state_r <= ST_EDGE;
        end
        ST_EDGE: begin
          step_r <= step_r + SLOT_W'(1);
          if (edge_hit) begin
            res_clear_r <= 1'b0;
            state_r     <= ST_FINISH;
          end else if (step_r == SLOT_W'(NUM_EDGES - 1)) begin
            if (last_obstacle) begin
              state_r <= ST_FINISH;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= ST_READ;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r      <= 1'b1;
            out_path_clear_r <= res_clear_r;
            out_table_full_r <= res_full_r;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.path_clear = out_path_clear_r;
  assign out_if.table_full = out_table_full_r;

endmodule

// ===== rtl/core/soc_port_checker.sv =====
// Port level checks of the collision check block and their binding to the top level.
`timescale 1ns / 1ps
`include "segment_obstacle_collision_check_macros.svh"

module soc_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_path_clear,
  input logic out_table_full
);

  logic [1:0] out_flags;
  logic       out_stall;

  assign out_flags = {out_path_clear, out_table_full};
  assign out_stall = out_valid && !out_ready;

  // No result is offered straight after reset.
  `SOC_ASSERT_RESET(a_no_result_after_reset, !out_valid, "result offered after reset")

  // The block works on one transaction at a time, so it is busy after taking one.
  `SOC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // A refused load never reports a clear path.
  `SOC_ASSERT_SAME(a_flags_exclusive, out_valid, out_flags != 2'b11, "both flags set")

  // A stalled result keeps its value.
  `SOC_ASSERT_NEXT(a_result_held, out_stall, out_valid && $stable(out_flags), "result changed")

endmodule

bind segment_obstacle_collision_check soc_port_checker u_port_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_path_clear (out_if.path_clear),
  .out_table_full (out_if.table_full)
);
